FILE: rtl/dtf16_pkg.sv
// ----------------------------------------------------------------------------
// dtf16_pkg
// Shared types and constants for the decimal text to 16.16 converter.
// ----------------------------------------------------------------------------
package dtf16_pkg;

    localparam int CHAR_W   = 8;
    localparam int INT_W    = 16;
    localparam int FRAC_W   = 25;
    localparam int RESULT_W = 32;
    localparam int DIGIT_W  = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

    localparam logic [FRAC_W-1:0] FRAC_START  = 25'd127;
    localparam logic [63:0]       SCALE_START = 64'h100_0000;
    localparam logic [63:0]       SCALE_MUL   = 64'd419430;
    localparam int                SCALE_SHIFT = 22;
    localparam int                SUM_SHIFT   = 8;

    // Scale per fraction digit position; by the last entry it has decayed to zero
    localparam int FRAC_POS_COUNT = 9;
    localparam int FRAC_POS_W     = $clog2(FRAC_POS_COUNT);
    localparam logic [FRAC_POS_W-1:0] FRAC_POS_MAX = FRAC_POS_W'(FRAC_POS_COUNT - 1);

    typedef logic [FRAC_W-1:0] t_scale;
    typedef t_scale t_scale_tab [FRAC_POS_COUNT];

    typedef struct packed {
        logic [INT_W-1:0]      int_acc;
        logic                  in_fraction;
        logic                  halted;
        logic [FRAC_POS_W-1:0] frac_pos;
        logic [FRAC_W-1:0]     frac_sum;
    } t_conv_state;

    localparam t_conv_state CONV_RESET = '{
        int_acc:     '0,
        in_fraction: 1'b0,
        halted:      1'b0,
        frac_pos:    '0,
        frac_sum:    FRAC_START
    };

    // Evaluated at elaboration only
    function automatic t_scale_tab build_scale_tab();
        t_scale_tab  tab;
        logic [63:0] s;
        s = SCALE_START;
        for (int k = 0; k < FRAC_POS_COUNT; k++) begin
            s = ((s * SCALE_MUL) >> SCALE_SHIFT) & 64'h1FF_FFFF;
            tab[k] = t_scale'(s);
        end
        return tab;
    endfunction

    localparam t_scale_tab SCALE_TAB = build_scale_tab();

endpackage

FILE: rtl/dtf16_step.sv
// ----------------------------------------------------------------------------
// dtf16_step
// One character of conversion: next state and the value of the text so far.
// ----------------------------------------------------------------------------
module dtf16_step (
    input  dtf16_pkg::t_conv_state              i_state,
    input  logic [dtf16_pkg::CHAR_W-1:0]        i_ch,
    input  logic                                i_ch_valid,
    input  logic                                i_last,
    output dtf16_pkg::t_conv_state              o_next,
    output logic [dtf16_pkg::RESULT_W-1:0]      o_value
);

    dtf16_pkg::t_conv_state                       upd;
    logic                                         is_digit;
    logic [dtf16_pkg::DIGIT_W-1:0]                digit;
    dtf16_pkg::t_scale                            scale;
    logic [dtf16_pkg::FRAC_W+dtf16_pkg::DIGIT_W-1:0] prod;
    logic [dtf16_pkg::INT_W+3:0]                  int_x10;

    always_comb begin
        is_digit = i_ch inside {[dtf16_pkg::CHAR_ZERO:dtf16_pkg::CHAR_NINE]};
        digit    = dtf16_pkg::DIGIT_W'(i_ch - dtf16_pkg::CHAR_ZERO);
        scale    = dtf16_pkg::SCALE_TAB[i_state.frac_pos];
        prod     = scale * digit;
        int_x10  = ({4'b0, i_state.int_acc} << 3) + ({4'b0, i_state.int_acc} << 1)
                   + (dtf16_pkg::INT_W+4)'(digit);

        upd = i_state;
        if (i_ch_valid && !i_state.halted) begin
            if (!i_state.in_fraction) begin
                if (is_digit) begin
                    upd.int_acc = int_x10[dtf16_pkg::INT_W-1:0];
                end else if (i_ch == dtf16_pkg::CHAR_DOT) begin
                    upd.in_fraction = 1'b1;
                end else begin
                    upd.halted = 1'b1;
                end
            end else begin
                if (is_digit) begin
                    upd.frac_sum = i_state.frac_sum + prod[dtf16_pkg::FRAC_W-1:0];
                    if (i_state.frac_pos != dtf16_pkg::FRAC_POS_MAX) begin
                        upd.frac_pos = i_state.frac_pos + 1'b1;
                    end
                end else begin
                    upd.halted = 1'b1;
                end
            end
        end

        o_value = {upd.int_acc, 16'b0}
                  + dtf16_pkg::RESULT_W'(upd.frac_sum >> dtf16_pkg::SUM_SHIFT);
        o_next  = i_last ? dtf16_pkg::CONV_RESET : upd;
    end

endmodule

FILE: rtl/decimal_text_to_fixed16_unit.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed16_unit
// Streams decimal text in, one character per transfer, and returns 16.16.
// ----------------------------------------------------------------------------
// Takes one character per cycle and returns one 16.16 value per string,
// the string ending at the transfer marked tlast. Characters pass an input
// register, then conversion logic (a table lookup of the fraction scale by
// digit position, a 25x4 multiply and an add) updates the conversion state;
// on tlast the value goes to the output register and the state clears for
// the next string. Throughput is one transfer per cycle; the slave side only
// stalls when a finished value waits in the output register while another
// tlast item is ready to be written. tuser[0] low marks a transfer with no
// character (empty string terminator). Digits before '.' wrap modulo 2^16;
// any other character halts conversion until the end of the string.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed16_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic [0:0]  i_s_tuser,   // [0] ch_valid
    input  logic        i_s_tlast,   // last_char
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] fixed_value
);

    // input register
    logic                           r_in_valid;
    logic [dtf16_pkg::CHAR_W-1:0]   r_in_ch;
    logic                           r_in_ch_valid;
    logic                           r_in_last;

    // conversion state
    dtf16_pkg::t_conv_state         r_state;
    dtf16_pkg::t_conv_state         n_state;
    logic [dtf16_pkg::RESULT_W-1:0] n_value;

    // output register
    logic                           r_out_valid;
    logic [dtf16_pkg::RESULT_W-1:0] r_out_data;

    logic out_free;
    logic stage_go;
    logic in_xfer;

    assign out_free   = !r_out_valid || i_m_tready;
    // items without tlast never need the output register
    assign stage_go   = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || stage_go;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    dtf16_step u_step (
        .i_state    (r_state),
        .i_ch       (r_in_ch),
        .i_ch_valid (r_in_ch_valid),
        .i_last     (r_in_last),
        .o_next     (n_state),
        .o_value    (n_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (in_xfer) begin
            r_in_ch       <= i_s_tdata;
            r_in_ch_valid <= i_s_tuser[0];
            r_in_last     <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtf16_pkg::CONV_RESET;
        end else if (stage_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (stage_go && r_in_last) begin
            r_out_data <= n_value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: rtl/dtf16_checker.sv
// ----------------------------------------------------------------------------
// dtf16_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module dtf16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // with nothing waiting at the output the slave side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("slave side stalled with empty output");

    // reset leaves nothing pending
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending right after reset");

    // a result can only appear once a tlast transfer has been taken
    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast, 2)
                              || $past(o_s_tready, 1) == 1'b0
                              || $past(i_s_tlast, 2) || !$past(i_rst_n, 2)
                              || $past(o_m_tvalid, 1) == 1'b0)
        else $error("result without string end");

endmodule

bind decimal_text_to_fixed16_unit dtf16_checker u_dtf16_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimal text to 16.16 converter.
// ----------------------------------------------------------------------------
// Character transfers are queued up front by the stimulus process and played
// out by a clocked driver. Each accepted transfer is folded into a local copy
// of the conversion state. A transfer marked tlast pushes the predicted 16.16
// value. A clocked monitor pops one prediction per accepted result and
// compares it with the value on the master side. Both sides take random idle
// bursts. The burst rate is re-drawn now and then, and zero is one of the
// rates it can draw. The tail of the run is free of idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CLK_HIGH     = 6;
    localparam int          CLK_LOW      = 6;
    localparam int          RESET_CYCLES = 12;
    localparam int          STALL_LIMIT  = 1000;  // cycles with no transfer on either side
    localparam int          QUIET_TAIL   = 150;   // last transfers sent with no idling
    localparam int          TARGET_CHARS = 1100;
    localparam int          DRAIN_CYCLES = 16;    // output passes an input and an output register
    localparam int          NOISE_PCT    = 5;     // chance of a no-character filler
    localparam logic [63:0] STEP_MUL     = 64'd419430;
    localparam int          STEP_SHIFT   = 22;
    localparam logic [24:0] SCALE_INIT   = 25'h100_0000;
    localparam logic [24:0] SUM_INIT     = 25'd127;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       is_last;
    } char_xfer_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] ch
    logic [0:0]  i_s_tuser  = '0;   // [0] ch_valid
    logic        i_s_tlast  = 1'b0; // last_char
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [31:0] fixed_value

    char_xfer_t  pending_chars[$];
    logic [31:0] expected_fixed[$];
    logic [7:0]  text_buf[$];
    int          chars_queued   = 0;
    int          error_count    = 0;
    int          idle_cycles    = 0;
    int          send_gap       = 0;
    int          recv_gap       = 0;
    int          send_idle_rate = 10;
    int          recv_idle_rate = 10;
    logic        tail_phase     = 1'b0;

    // Local copy of the conversion state
    logic [15:0] conv_int;
    logic        conv_in_frac;
    logic        conv_halted;
    logic [24:0] conv_scale;
    logic [24:0] conv_sum;

    decimal_text_to_fixed16_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    function automatic void clear_conversion();
        conv_int     = '0;
        conv_in_frac = 1'b0;
        conv_halted  = 1'b0;
        conv_scale   = SCALE_INIT;
        conv_sum     = SUM_INIT;
    endfunction

    // Folds one accepted transfer into the state; tlast yields the 16.16 value
    function automatic void convert_char(input logic [7:0] ch, input logic has_char,
                                         input logic is_last);
        logic        is_digit;
        logic [3:0]  digit;
        logic [63:0] prod;
        is_digit = (ch >= dtf16_pkg::CHAR_ZERO) && (ch <= dtf16_pkg::CHAR_NINE);
        digit    = 4'(ch - dtf16_pkg::CHAR_ZERO);
        if (has_char && !conv_halted) begin
            if (!conv_in_frac) begin
                if (is_digit) begin
                    conv_int = 16'(32'(conv_int) * 10 + 32'(digit));
                end else if (ch == dtf16_pkg::CHAR_DOT) begin
                    conv_in_frac = 1'b1;
                end else begin
                    conv_halted = 1'b1;
                end
            end else if (is_digit) begin
                // scale steps down to about a tenth per fraction digit
                prod       = (64'(conv_scale) * STEP_MUL) >> STEP_SHIFT;
                conv_scale = prod[24:0];
                conv_sum   = 25'(conv_sum + conv_scale * 25'(digit));
            end else begin
                conv_halted = 1'b1;
            end
        end
        if (is_last) begin
            expected_fixed.push_back({conv_int, 16'h0000} + 32'(conv_sum >> 8));
            clear_conversion();
        end
    endfunction

    task automatic queue_xfer(input logic [7:0] ch, input logic has_char,
                              input logic is_last);
        pending_chars.push_back('{ch: ch, has_char: has_char, is_last: is_last});
        if (has_char || is_last) begin
            chars_queued++;
        end
    endtask

    // Sends text_buf as one string; tlast either on the final character or on
    // a separate no-character transfer. Fillers with no character are mixed in.
    task automatic emit_text(input bit with_term, input int noise_pct);
        for (int k = 0; k < text_buf.size(); k++) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                queue_xfer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            queue_xfer(text_buf[k], 1'b1, !with_term && (k == text_buf.size() - 1));
        end
        if (with_term || text_buf.size() == 0) begin
            queue_xfer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic emit_string(input string s, input bit with_term);
        text_buf.delete();
        foreach (s[k]) begin
            text_buf.push_back(8'(s[k]));
        end
        emit_text(with_term, 0);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(dtf16_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    initial begin : stimulus
        int         n_int;
        int         n_frac;
        int         n_tail;
        bit         all_nines;
        logic [7:0] bad;
        string      top_int;
        top_int = "65535";
        clear_conversion();

        // Directed strings
        emit_string("", 1'b1);             // empty string: value 0
        emit_string("65536", 1'b0);        // integer part wraps to 0
        emit_string("1.5", 1'b1);          // fraction, closed by a no-character transfer
        emit_string("65535.999999", 1'b0); // fraction carries into the integer field
        emit_string("..", 1'b0);           // second point halts
        emit_string("3/:", 1'b0);          // characters either side of the digit range
        text_buf.delete();
        text_buf.push_back(8'hFF);
        emit_text(1'b0, 0);
        queue_xfer("4", 1'b1, 1'b0);       // filler mid string changes nothing
        queue_xfer(8'hA5, 1'b0, 1'b0);
        queue_xfer("2", 1'b1, 1'b1);

        // Random strings: mostly well formed, some raw bytes, some broken tails
        while (chars_queued < TARGET_CHARS) begin
            text_buf.delete();
            if ($urandom_range(0, 9) == 0) begin
                n_tail = $urandom_range(1, 6);
                repeat (n_tail) text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 6) == 0) begin
                    foreach (top_int[k]) text_buf.push_back(8'(top_int[k]));
                end else begin
                    n_int = $urandom_range(0, 7);
                    repeat (n_int) text_buf.push_back(rand_digit());
                end
                if ($urandom_range(0, 3) != 0) begin
                    text_buf.push_back(dtf16_pkg::CHAR_DOT);
                    n_frac    = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14)
                                                            : $urandom_range(0, 7);
                    all_nines = ($urandom_range(0, 4) == 0);
                    repeat (n_frac) begin
                        text_buf.push_back(all_nines ? dtf16_pkg::CHAR_NINE
                                                     : rand_digit());
                    end
                end
                if ($urandom_range(0, 6) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        bad = dtf16_pkg::CHAR_DOT;
                    end else begin
                        bad = 8'($urandom_range(0, 255));
                        while (bad >= dtf16_pkg::CHAR_ZERO && bad <= dtf16_pkg::CHAR_NINE) begin
                            bad = 8'($urandom_range(0, 255));
                        end
                    end
                    text_buf.push_back(bad);
                    n_tail = $urandom_range(0, 3);
                    repeat (n_tail) text_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            emit_text($urandom_range(0, 3) == 0, NOISE_PCT);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || expected_fixed.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Slave-side driver: holds a transfer until accepted, idles in bursts
    always @(posedge i_clk) begin : char_driver
        char_xfer_t head;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                convert_char(i_s_tdata, i_s_tuser[0], i_s_tlast);
                void'(pending_chars.pop_front());
                if (i_s_tlast && $urandom_range(0, 9) == 0) begin
                    send_idle_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
                end
            end
            tail_phase <= (pending_chars.size() < QUIET_TAIL);
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (!tail_phase && send_idle_rate != 0 &&
                             $urandom_range(1, 100) <= send_idle_rate) begin
                    send_gap = $urandom_range(0, 18);
                    i_s_tvalid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    head = pending_chars[0];
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= head.ch;
                    i_s_tuser  <= head.has_char;
                    i_s_tlast  <= head.is_last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side back-pressure
    always @(posedge i_clk) begin : result_sink
        if (recv_gap > 0) begin
            recv_gap--;
            i_m_tready <= 1'b0;
        end else if (!tail_phase && recv_idle_rate != 0 &&
                     $urandom_range(1, 100) <= recv_idle_rate) begin
            recv_gap = $urandom_range(0, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
        if (o_m_tvalid && i_m_tready && $urandom_range(0, 9) == 0) begin
            recv_idle_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
        end
    end

    // Result checker: one prediction per accepted result, oldest first
    always @(posedge i_clk) begin : result_check
        logic [31:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_fixed.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_m_tdata);
                error_count++;
            end else begin
                want = expected_fixed.pop_front();
                if (o_m_tdata !== want) begin
                    $display("%0t: fixed_value mismatch, expected %h, actual %h",
                             $time, want, o_m_tdata);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long with no transfer on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
rtl/dtf16_pkg.sv
rtl/dtf16_step.sv
rtl/decimal_text_to_fixed16_unit.sv
rtl/dtf16_checker.sv
tb/tb_top.sv
